// File: src/dahdsr_pkg.sv
`timescale 1ns / 1ps
// dahdsr_pkg: types, constants and the control store of the envelope gain sequencer
// no dependencies; imported by dahdsr_envelope_gain_top
package dahdsr_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELAY,
		ST_ATTACK,
		ST_HOLD,
		ST_DECAY,
		ST_SUSTAIN,
		ST_RELEASE
	} stage_t;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		REG_DELAY,
		REG_ATTACK,
		REG_HOLD,
		REG_DECAY,
		REG_SUSTAIN,
		REG_RELEASE
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] sample_in;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic [2:0]         stage;
	} res_t;

	typedef enum logic [2:0] {
		SEQ_FETCH,
		SEQ_NEXT,
		SEQ_JUMP,
		SEQ_JCOND,
		SEQ_EMIT
	} seq_t;

	typedef enum logic [1:0] {
		COND_IDLE,
		COND_NO_REGION,
		COND_NO_DIV,
		COND_DIV_MORE
	} cond_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_NOTE_ON,
		ACT_NOTE_OFF,
		ACT_REGION,
		ACT_DIV_STEP,
		ACT_DIV_DONE,
		ACT_ADVANCE,
		ACT_MUL
	} act_t;

	typedef logic [4:0] pc_t;

	typedef struct packed {
		seq_t  seq;
		cond_t cond;
		act_t  act;
		logic  zero_out;
		pc_t   target;
	} uctl_t;

	typedef struct packed {
		logic        go;
		logic        neg;
		logic [16:0] mag;
		logic [18:0] den;
		logic        sh3;
	} div_req_t;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [16:0] UNITY       = 17'h10000;
	localparam logic [15:0] FULL_GROUPS = 16'hFFFF;
	localparam logic [4:0]  DIV_STEPS   = 5'd17;

	localparam logic [15:0] RST_DELAY   = 16'd0;
	localparam logic [15:0] RST_ATTACK  = 16'd58;
	localparam logic [15:0] RST_HOLD    = 16'd138;
	localparam logic [15:0] RST_DECAY   = 16'd193;
	localparam logic [16:0] RST_SUSTAIN = 17'd43690;
	localparam logic [15:0] RST_RELEASE = 16'd1654;

	localparam pc_t PC_FETCH     = 5'd0;
	localparam pc_t PC_NOTE_ON   = 5'd1;
	localparam pc_t PC_NOTE_OFF  = 5'd2;
	localparam pc_t PC_SAMPLE    = 5'd3;
	localparam pc_t PC_CHK_REG   = 5'd4;
	localparam pc_t PC_REGION    = 5'd5;
	localparam pc_t PC_CHK_DIV   = 5'd6;
	localparam pc_t PC_S_DIV     = 5'd7;
	localparam pc_t PC_S_DONE    = 5'd8;
	localparam pc_t PC_LIVE      = 5'd9;
	localparam pc_t PC_ADVANCE   = 5'd10;
	localparam pc_t PC_MUL       = 5'd11;
	localparam pc_t PC_EMIT      = 5'd12;
	localparam pc_t PC_EMIT_ZERO = 5'd13;
	localparam pc_t PC_NOTE_DIV  = 5'd14;
	localparam pc_t PC_N_DIV     = 5'd15;
	localparam pc_t PC_N_DONE    = 5'd16;

	function automatic uctl_t ucode(input pc_t pc);
		uctl_t w;
		w = '{SEQ_JUMP, COND_IDLE, ACT_NONE, 1'b0, PC_FETCH};
		case (pc)
			PC_FETCH:     w = '{SEQ_FETCH, COND_IDLE, ACT_NONE, 1'b0, PC_FETCH};
			PC_NOTE_ON:   w = '{SEQ_JUMP, COND_IDLE, ACT_NOTE_ON, 1'b0, PC_NOTE_DIV};
			PC_NOTE_OFF:  w = '{SEQ_JUMP, COND_IDLE, ACT_NOTE_OFF, 1'b0, PC_NOTE_DIV};
			PC_SAMPLE:    w = '{SEQ_JCOND, COND_IDLE, ACT_NONE, 1'b0, PC_EMIT_ZERO};
			PC_CHK_REG:   w = '{SEQ_JCOND, COND_NO_REGION, ACT_NONE, 1'b0, PC_LIVE};
			PC_REGION:    w = '{SEQ_NEXT, COND_IDLE, ACT_REGION, 1'b0, PC_FETCH};
			PC_CHK_DIV:   w = '{SEQ_JCOND, COND_NO_DIV, ACT_NONE, 1'b0, PC_LIVE};
			PC_S_DIV:     w = '{SEQ_JCOND, COND_DIV_MORE, ACT_DIV_STEP, 1'b0, PC_S_DIV};
			PC_S_DONE:    w = '{SEQ_NEXT, COND_IDLE, ACT_DIV_DONE, 1'b0, PC_FETCH};
			PC_LIVE:      w = '{SEQ_JCOND, COND_IDLE, ACT_NONE, 1'b0, PC_EMIT_ZERO};
			PC_ADVANCE:   w = '{SEQ_NEXT, COND_IDLE, ACT_ADVANCE, 1'b0, PC_FETCH};
			PC_MUL:       w = '{SEQ_NEXT, COND_IDLE, ACT_MUL, 1'b0, PC_FETCH};
			PC_EMIT:      w = '{SEQ_EMIT, COND_IDLE, ACT_NONE, 1'b0, PC_FETCH};
			PC_EMIT_ZERO: w = '{SEQ_EMIT, COND_IDLE, ACT_NONE, 1'b1, PC_FETCH};
			PC_NOTE_DIV:  w = '{SEQ_JCOND, COND_NO_DIV, ACT_NONE, 1'b0, PC_FETCH};
			PC_N_DIV:     w = '{SEQ_JCOND, COND_DIV_MORE, ACT_DIV_STEP, 1'b0, PC_N_DIV};
			PC_N_DONE:    w = '{SEQ_JUMP, COND_IDLE, ACT_DIV_DONE, 1'b0, PC_FETCH};
			default:      w = '{SEQ_JUMP, COND_IDLE, ACT_NONE, 1'b0, PC_FETCH};
		endcase
		return w;
	endfunction

endpackage

// File: src/dahdsr_envelope_gain_top.sv
`timescale 1ns / 1ps
// dahdsr_envelope_gain_top: microcoded dahdsr envelope applied as gain to 16-bit audio
// depends on dahdsr_pkg (types, constants, control store)

// The block takes one command word at a time (sample, note on, note off) and
// returns one result word per audio sample. A sample goes straight to its emit
// step with a zero output when the envelope is idle. A region change that needs a
// new step, and every note on or note off that starts a ramp, runs the
// 17-step restoring divider shared by all step calculations. A note on into a
// delay stage starts no division, and an unused op code returns to fetch. A result
// word that is not taken holds the sequencer at its emit step until the receiver
// releases the stall.
module dahdsr_envelope_gain_top
	import dahdsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_t              cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [15:0] delay_q, attack_q, hold_q, decay_q, release_q;
	logic [16:0] sustain_q;

	pc_t   pc_q, pc_next;
	uctl_t uc;
	logic  cond_true;
	logic  slot_free;
	logic  cfg_wr;

	logic [1:0]         op_q;
	logic signed [15:0] smp_q;

	stage_t             stage_q;
	logic [15:0]        groups_q;
	logic signed [31:0] level_q;
	logic signed [31:0] step_q;
	logic [2:0]         phase_q;

	logic [18:0] div_rem_q, div_den_q;
	logic [16:0] div_quo_q;
	logic [4:0]  div_cnt_q;
	logic        div_neg_q, div_sh3_q, div_pend_q;
	logic [19:0] trial;
	logic        trial_ge;
	logic signed [31:0] div_full, div_res;

	logic signed [47:0] prod_q;
	logic               res_valid_q;
	res_t               res_q;

	logic [15:0]        att_g, dec_g, rel_g;
	logic signed [17:0] diff;
	logic [16:0]        diff_mag;
	div_req_t           req;

	assign pready    = 1'b1;
	assign cfg_wr    = psel & penable & pwrite;
	assign uc        = ucode(pc_q);
	assign cmd_stall = (pc_q != PC_FETCH);
	assign slot_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// register read
	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_DELAY:   prdata = {16'h0, delay_q};
			REG_ATTACK:  prdata = {16'h0, attack_q};
			REG_HOLD:    prdata = {16'h0, hold_q};
			REG_DECAY:   prdata = {16'h0, decay_q};
			REG_SUSTAIN: prdata = {15'h0, sustain_q};
			REG_RELEASE: prdata = {16'h0, release_q};
			default:     prdata = '0;
		endcase
	end

	// sequencer conditions
	always_comb begin
		case (uc.cond)
			COND_IDLE:      cond_true = (stage_q == ST_IDLE);
			COND_NO_REGION: cond_true = !((phase_q == 3'd0) && (groups_q == 16'd0));
			COND_NO_DIV:    cond_true = !div_pend_q;
			COND_DIV_MORE:  cond_true = (div_cnt_q != 5'd1);
			default:        cond_true = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		pc_next = pc_q;
		case (uc.seq)
			SEQ_FETCH: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_SAMPLE:   pc_next = PC_SAMPLE;
						OP_NOTE_ON:  pc_next = PC_NOTE_ON;
						OP_NOTE_OFF: pc_next = PC_NOTE_OFF;
						default:     pc_next = PC_FETCH;
					endcase
				end
			end
			SEQ_NEXT:  pc_next = pc_q + 5'd1;
			SEQ_JUMP:  pc_next = uc.target;
			SEQ_JCOND: pc_next = cond_true ? uc.target : pc_q + 5'd1;
			SEQ_EMIT:  pc_next = slot_free ? PC_FETCH : pc_q;
			default:   pc_next = PC_FETCH;
		endcase
	end

	// step divider setup
	always_comb begin
		att_g    = (attack_q == 16'd0) ? 16'd1 : attack_q;
		dec_g    = (decay_q == 16'd0) ? 16'd1 : decay_q;
		rel_g    = (release_q == 16'd0) ? 16'd1 : release_q;
		diff     = $signed({1'b0, sustain_q}) - $signed({1'b0, UNITY});
		diff_mag = diff[17] ? 17'(-diff) : diff[16:0];
		req      = '0;
		case (uc.act)
			ACT_NOTE_ON: begin
				if (delay_q == 16'd0) begin
					req = '{1'b1, 1'b0, UNITY, {3'b000, att_g}, 1'b1};
				end
			end
			ACT_NOTE_OFF: begin
				req = '{1'b1, 1'b1, sustain_q, {rel_g, 3'b000}, 1'b0};
			end
			ACT_REGION: begin
				case (stage_q)
					ST_DELAY:  req = '{1'b1, 1'b0, UNITY, {3'b000, att_g}, 1'b1};
					ST_ATTACK: begin
						if (hold_q == 16'd0) begin
							req = '{1'b1, diff[17], diff_mag, {dec_g, 3'b000}, 1'b0};
						end
					end
					ST_HOLD:   req = '{1'b1, diff[17], diff_mag, {3'b000, dec_g}, 1'b1};
					default:   req = '0;
				endcase
			end
			default: req = '0;
		endcase
	end

	// restoring divider datapath
	always_comb begin
		trial    = {div_rem_q, div_quo_q[16]};
		trial_ge = (trial >= {1'b0, div_den_q});
		div_full = div_neg_q ? -$signed({15'b0, div_quo_q}) : $signed({15'b0, div_quo_q});
		div_res  = div_sh3_q ? (div_full >>> 3) : div_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_FETCH;
			delay_q     <= RST_DELAY;
			attack_q    <= RST_ATTACK;
			hold_q      <= RST_HOLD;
			decay_q     <= RST_DECAY;
			sustain_q   <= RST_SUSTAIN;
			release_q   <= RST_RELEASE;
			stage_q     <= ST_IDLE;
			groups_q    <= '0;
			level_q     <= '0;
			step_q      <= '0;
			phase_q     <= '0;
			div_cnt_q   <= '0;
			div_pend_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;

			if (cfg_wr) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_DELAY:   delay_q   <= pwdata[15:0];
					REG_ATTACK:  attack_q  <= pwdata[15:0];
					REG_HOLD:    hold_q    <= pwdata[15:0];
					REG_DECAY:   decay_q   <= pwdata[15:0];
					REG_SUSTAIN: sustain_q <= pwdata[16:0];
					REG_RELEASE: release_q <= pwdata[15:0];
					default: ;
				endcase
			end

			case (uc.act)
				ACT_NOTE_ON: begin
					level_q    <= '0;
					phase_q    <= '0;
					div_pend_q <= req.go;
					if (delay_q != 16'd0) begin
						stage_q  <= ST_DELAY;
						groups_q <= delay_q;
						step_q   <= '0;
					end else begin
						stage_q  <= ST_ATTACK;
						groups_q <= att_g;
					end
				end
				ACT_NOTE_OFF: begin
					stage_q    <= ST_RELEASE;
					phase_q    <= '0;
					groups_q   <= rel_g;
					level_q    <= $signed({15'b0, sustain_q});
					div_pend_q <= req.go;
				end
				ACT_REGION: begin
					div_pend_q <= req.go;
					case (stage_q)
						ST_DELAY: begin
							stage_q  <= ST_ATTACK;
							groups_q <= att_g;
						end
						ST_ATTACK: begin
							if (hold_q != 16'd0) begin
								stage_q  <= ST_HOLD;
								groups_q <= hold_q;
								level_q  <= $signed({15'b0, UNITY});
								step_q   <= '0;
							end else begin
								stage_q  <= ST_DECAY;
								groups_q <= dec_g;
							end
						end
						ST_HOLD: begin
							stage_q  <= ST_DECAY;
							groups_q <= dec_g;
						end
						ST_DECAY: begin
							stage_q  <= ST_SUSTAIN;
							groups_q <= FULL_GROUPS;
							level_q  <= $signed({15'b0, sustain_q});
							step_q   <= '0;
						end
						ST_SUSTAIN: groups_q <= FULL_GROUPS;
						default:    stage_q  <= ST_IDLE;
					endcase
				end
				ACT_DIV_STEP: div_cnt_q <= div_cnt_q - 5'd1;
				ACT_DIV_DONE: step_q <= div_res;
				ACT_ADVANCE: begin
					level_q <= level_q + step_q;
					phase_q <= phase_q + 3'd1;
					if (phase_q == 3'd7) begin
						groups_q <= groups_q - 16'd1;
					end
				end
				default: ;
			endcase

			if (req.go) begin
				div_cnt_q <= DIV_STEPS;
			end

			if (uc.seq == SEQ_EMIT && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (uc.seq == SEQ_FETCH && cmd_valid) begin
			op_q  <= cmd.op;
			smp_q <= cmd.sample_in;
		end
		if (req.go) begin
			div_rem_q <= '0;
			div_quo_q <= req.mag;
			div_den_q <= req.den;
			div_neg_q <= req.neg;
			div_sh3_q <= req.sh3;
		end else if (uc.act == ACT_DIV_STEP) begin
			div_rem_q <= trial_ge ? 19'(trial - {1'b0, div_den_q}) : trial[18:0];
			div_quo_q <= {div_quo_q[15:0], trial_ge};
		end
		if (uc.act == ACT_MUL) begin
			prod_q <= level_q * smp_q;
		end
		if (uc.seq == SEQ_EMIT && slot_free) begin
			res_q.sample_out <= uc.zero_out ? 16'sd0 : prod_q[31:16];
			res_q.stage      <= stage_q;
		end
	end

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.stage == ST_IDLE) |-> (res.sample_out == 16'sd0))
		else $error("idle result word carries a nonzero sample");

	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |-> (div_cnt_q == 5'd0))
		else $error("command word accepted while divider is running");

	a_unused_op: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && (cmd.op == OP_NONE) |=> !cmd_stall)
		else $error("unused op code did not return to fetch");

	a_op_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_SAMPLE) |-> (op_q == OP_SAMPLE))
		else $error("sample path entered for a non-sample command");

endmodule
